// ===== hw/rtl/adsr_pkg.sv =====
// Shared types, codes and constants for the linear ADSR envelope generator.
package adsr_pkg;

   // Default widths of the stage lengths and of the envelope level
   localparam int LENGTH_BITS_DEF = 20;
   localparam int LEVEL_BITS_DEF  = 16;

   // Fixed field widths
   localparam int REQ_BITS       = 2;
   localparam int NOTE_BITS      = 7;
   localparam int STAGE_BITS     = 3;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DECAY   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SUSTAIN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE = 2'd3;

   // Register reset values, truncated to the configured widths where used
   localparam logic [31:0] LENGTH_RESET  = 32'd500000;
   localparam logic [31:0] SUSTAIN_RESET = 32'd32768;

   // Request codes
   localparam logic [REQ_BITS-1:0] REQ_TICK     = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_NOTE_ON  = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_NOTE_OFF = 2'd2;

   // Envelope stages
   typedef enum logic [STAGE_BITS-1:0] {
      STG_IDLE    = 3'd0,
      STG_RELEASE = 3'd1,
      STG_SUSTAIN = 3'd2,
      STG_DECAY   = 3'd3,
      STG_ATTACK  = 3'd4
   } stage_type;

   // Controller states
   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_MUL,
      FSM_DIV,
      FSM_FINISH
   } fsm_state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic mul_load;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== hw/rtl/adsr_req_if.sv =====
// Request channel: valid/ready handshake carrying one request word.
interface adsr_req_if;
   import adsr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [REQ_BITS-1:0]  req_type;
   logic [NOTE_BITS-1:0] note_number;

   modport source (output valid, req_type, note_number, input ready);
   modport sink (input valid, req_type, note_number, output ready);
   modport monitor (input valid, ready, req_type, note_number);

endinterface

// ===== hw/rtl/adsr_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the envelope level and stage.
interface adsr_rsp_if #(
   parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
);
   import adsr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [LEVEL_BITS-1:0] env_level;
   logic [STAGE_BITS-1:0] env_stage;

   modport source (output valid, env_level, env_stage, input ready);
   modport sink (input valid, env_level, env_stage, output ready);
   modport monitor (input valid, ready, env_level, env_stage);

endinterface

// ===== hw/rtl/adsr_ctrl.sv =====
// Sequencing state machine: accept, multiply and divide when a ramp step needs it, then commit the result.
module adsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  adsr_pkg::dp_sts_type  sts,
   output adsr_pkg::dp_cmd_type  cmd
);
   import adsr_pkg::*;

   fsm_state_type state_ff;
   fsm_state_type state_in;
   logic          req_fire;

   assign req_fire = req_valid && req_ready;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (req_fire) begin
               state_in = sts.need_div ? FSM_MUL : FSM_FINISH;
            end
         end
         FSM_MUL: begin
            state_in = FSM_DIV;
         end
         FSM_DIV: begin
            if (sts.div_last) begin
               state_in = FSM_FINISH;
            end
         end
         FSM_FINISH: begin
            if (sts.out_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Drive handshake and datapath commands
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         FSM_MUL: begin
            cmd.mul_load = 1'b1;
         end
         FSM_DIV: begin
            cmd.div_step = 1'b1;
         end
         FSM_FINISH: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/adsr_dp.sv =====
// Datapath: registers, envelope state, ramp multiplier, serial divider, output word.
module adsr_dp #(
   parameter int LENGTH_BITS   = adsr_pkg::LENGTH_BITS_DEF,
   parameter int LEVEL_BITS    = adsr_pkg::LEVEL_BITS_DEF,
   parameter int CSR_DATA_BITS = (LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  adsr_pkg::dp_cmd_type                   cmd,
   output adsr_pkg::dp_sts_type                   sts,
   input  logic [adsr_pkg::REQ_BITS-1:0]          req_type,
   input  logic [adsr_pkg::NOTE_BITS-1:0]         note_number,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [LEVEL_BITS-1:0]                  env_level,
   output logic [adsr_pkg::STAGE_BITS-1:0]        env_stage,
   input  logic                                   csr_wr_en,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]               csr_wdata
);
   import adsr_pkg::*;

   localparam int PROD_BITS = LENGTH_BITS + LEVEL_BITS + 1;
   localparam int STEP_BITS = $clog2(LEVEL_BITS + 1);
   localparam logic [STEP_BITS-1:0]    STEP_LAST  = STEP_BITS'(LEVEL_BITS);
   localparam logic [LEVEL_BITS:0]     FULL_SCALE = {1'b1, {LEVEL_BITS{1'b0}}};
   localparam logic [LEVEL_BITS-1:0]   LEVEL_MAX  = {LEVEL_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0]  LEN_RST    = LENGTH_RESET[LENGTH_BITS-1:0];
   localparam logic [LEVEL_BITS-1:0]   SUS_RST    = SUSTAIN_RESET[LEVEL_BITS-1:0];

   // Configuration registers
   logic [LENGTH_BITS-1:0] attack_len_ff;
   logic [LENGTH_BITS-1:0] decay_len_ff;
   logic [LENGTH_BITS-1:0] release_len_ff;
   logic [LEVEL_BITS-1:0]  sustain_ff;

   // Envelope state
   stage_type              stage_ff, stage_in;
   logic [LENGTH_BITS-1:0] run_ff, run_in;
   logic [LEVEL_BITS-1:0]  level_ff, level_in;
   logic [LEVEL_BITS-1:0]  atk_start_ff, atk_start_in;
   logic [LEVEL_BITS-1:0]  rel_start_ff, rel_start_in;
   logic [NOTE_BITS-1:0]   held_note_ff, held_note_in;

   // Item in flight
   logic [REQ_BITS-1:0]    req_type_ff;
   logic [NOTE_BITS-1:0]   note_ff;
   logic [LENGTH_BITS-1:0] count_ff;

   // Divider
   logic [LENGTH_BITS-1:0] div_len_ff;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [LEVEL_BITS:0]    quo_ff, quo_in;
   logic [STEP_BITS-1:0]   step_ff;

   // Output word
   logic                   rsp_valid_ff;
   logic [LEVEL_BITS-1:0]  out_level_ff;
   stage_type              out_stage_ff;

   logic [LENGTH_BITS-1:0] cur_len;
   logic [LENGTH_BITS-1:0] dec_count;
   logic [LENGTH_BITS-1:0] new_count;
   logic                   ramp_stage;
   logic [LENGTH_BITS-1:0] mul_k;
   logic [LEVEL_BITS:0]    mul_m;
   logic [PROD_BITS-1:0]   product;
   logic [LENGTH_BITS:0]   trial;
   logic [LENGTH_BITS:0]   trial_diff;
   logic                   trial_ge;
   logic [LEVEL_BITS-1:0]  sum_base;
   logic [LEVEL_BITS+1:0]  ramp_sum;
   logic [LEVEL_BITS-1:0]  ramp_level;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= LEN_RST;
         decay_len_ff   <= LEN_RST;
         sustain_ff     <= SUS_RST;
         release_len_ff <= LEN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ATTACK:  attack_len_ff  <= csr_wdata[LENGTH_BITS-1:0];
            CSR_DECAY:   decay_len_ff   <= csr_wdata[LENGTH_BITS-1:0];
            CSR_SUSTAIN: sustain_ff     <= csr_wdata[LEVEL_BITS-1:0];
            CSR_RELEASE: release_len_ff <= csr_wdata[LENGTH_BITS-1:0];
            default:     sustain_ff     <= sustain_ff;
         endcase
      end
   end

   // Select the length of the current ramp stage
   always_comb begin
      case (stage_ff)
         STG_ATTACK:  cur_len = attack_len_ff;
         STG_DECAY:   cur_len = decay_len_ff;
         STG_RELEASE: cur_len = release_len_ff;
         default:     cur_len = '0;
      endcase
   end

   // Count down, floored at zero and clamped to the stage length
   assign dec_count  = (run_ff == '0) ? '0 : run_ff - LENGTH_BITS'(1);
   assign new_count  = (dec_count > cur_len) ? cur_len : dec_count;
   assign ramp_stage = stage_ff inside {STG_ATTACK, STG_DECAY, STG_RELEASE};

   assign sts.need_div = (req_type == REQ_TICK) && ramp_stage && (new_count != '0);

   // Latch the request word and its count
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_type_ff <= req_type;
         note_ff     <= note_number;
         count_ff    <= new_count;
      end
   end

   // Pick the ramp factors
   always_comb begin
      mul_k = count_ff;
      mul_m = '0;
      case (stage_ff)
         STG_ATTACK: begin
            mul_k = cur_len - count_ff;
            mul_m = FULL_SCALE - {1'b0, atk_start_ff};
         end
         STG_DECAY: begin
            mul_m = FULL_SCALE - {1'b0, sustain_ff};
         end
         STG_RELEASE: begin
            mul_m = {1'b0, rel_start_ff};
         end
         default: begin
            mul_m = '0;
         end
      endcase
   end

   assign product = {{(LEVEL_BITS+1){1'b0}}, mul_k} * {{LENGTH_BITS{1'b0}}, mul_m};

   // One restoring division step: one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[LEVEL_BITS]};
   assign trial_diff = trial - {1'b0, div_len_ff};
   assign trial_ge   = trial >= {1'b0, div_len_ff};
   assign rem_in     = trial_ge ? trial_diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
   assign quo_in     = {quo_ff[LEVEL_BITS-1:0], trial_ge};

   // Load the product into the divider, then shift it through
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         rem_ff     <= product[PROD_BITS-1:LEVEL_BITS+1];
         quo_ff     <= product[LEVEL_BITS:0];
         div_len_ff <= cur_len;
         step_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         step_ff <= step_ff + STEP_BITS'(1);
      end
   end

   assign sts.div_last = (step_ff == STEP_LAST);

   // Add the ramp base and saturate
   always_comb begin
      case (stage_ff)
         STG_ATTACK: sum_base = atk_start_ff;
         STG_DECAY:  sum_base = sustain_ff;
         default:    sum_base = '0;
      endcase
   end

   assign ramp_sum   = {2'b00, sum_base} + {1'b0, quo_ff};
   assign ramp_level = (ramp_sum[LEVEL_BITS+1:LEVEL_BITS] != 2'b00) ? LEVEL_MAX
                                                                     : ramp_sum[LEVEL_BITS-1:0];

   // Next envelope state for the latched request
   always_comb begin
      stage_in     = stage_ff;
      run_in       = run_ff;
      level_in     = level_ff;
      atk_start_in = atk_start_ff;
      rel_start_in = rel_start_ff;
      held_note_in = held_note_ff;
      case (req_type_ff)
         REQ_TICK: begin
            case (stage_ff)
               STG_ATTACK: begin
                  if (count_ff == '0) begin
                     run_in   = decay_len_ff;
                     stage_in = STG_DECAY;
                  end else begin
                     run_in   = count_ff;
                     level_in = ramp_level;
                  end
               end
               STG_DECAY: begin
                  run_in = count_ff;
                  if (count_ff == '0) begin
                     stage_in = STG_SUSTAIN;
                  end else begin
                     level_in = ramp_level;
                  end
               end
               STG_SUSTAIN: begin
                  level_in = sustain_ff;
               end
               STG_RELEASE: begin
                  run_in = count_ff;
                  if (count_ff == '0) begin
                     stage_in = STG_IDLE;
                     level_in = '0;
                  end else begin
                     level_in = ramp_level;
                  end
               end
               default: begin
                  stage_in = stage_ff;
               end
            endcase
         end
         REQ_NOTE_ON: begin
            held_note_in = note_ff;
            run_in       = attack_len_ff;
            stage_in     = STG_ATTACK;
            atk_start_in = level_ff;
         end
         REQ_NOTE_OFF: begin
            if (note_ff == held_note_ff) begin
               run_in       = release_len_ff;
               stage_in     = STG_RELEASE;
               rel_start_in = level_ff;
            end
         end
         default: begin
            stage_in = stage_ff;
         end
      endcase
   end

   // Commit envelope state
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STG_IDLE;
         run_ff       <= '0;
         level_ff     <= '0;
         atk_start_ff <= '0;
         rel_start_ff <= '0;
         held_note_ff <= '0;
      end else if (cmd.commit) begin
         stage_ff     <= stage_in;
         run_ff       <= run_in;
         level_ff     <= level_in;
         atk_start_ff <= atk_start_in;
         rel_start_ff <= rel_start_in;
         held_note_ff <= held_note_in;
      end
   end

   // Hold the output word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_level_ff <= level_in;
         out_stage_ff <= stage_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign env_level    = out_level_ff;
   assign env_stage    = out_stage_ff;

endmodule

// ===== hw/rtl/adsr_envelope_generator_top.sv =====
// Top level of the linear ADSR envelope generator.
//
// Usage:
//   req_ch carries one request word per handshake: req_type (sample tick,
//   note on, note off) and note_number. rsp_ch returns exactly one word per
//   request: the envelope level after it (unsigned Q0.LEVEL_BITS, truncated)
//   and the stage. Registers are written through csr_wr_en / csr_index /
//   csr_wdata while no request is in flight.
// Timing:
//   A tick that steps a ramp in attack, decay or release passes through these
//   phases from acceptance to the response word: take the word, one ramp
//   multiply, LEVEL_BITS + 1 divide steps, one commit. Any other request, a
//   tick that ends its stage included, goes from taking the word straight to
//   the commit. One request is in work at a time; req_ch.ready is high again
//   in the cycle after the response is registered.
// Reset:
//   Synchronous reset returns the envelope to idle at level zero, loads the
//   register defaults and drops rsp_ch.valid.
// Stall:
//   The response word sits in an output register until taken; a finished
//   request waits in its commit cycle while that register is still full.
module adsr_envelope_generator_top #(
   parameter int LENGTH_BITS = adsr_pkg::LENGTH_BITS_DEF,
   parameter int LEVEL_BITS  = adsr_pkg::LEVEL_BITS_DEF,
   parameter int CSR_DATA_BITS = (LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   adsr_req_if.sink                            req_ch,
   adsr_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [adsr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]            csr_wdata
);
   import adsr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequence each request
   adsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Compute the envelope
   adsr_dp #(
      .LENGTH_BITS   (LENGTH_BITS),
      .LEVEL_BITS    (LEVEL_BITS),
      .CSR_DATA_BITS (CSR_DATA_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_type    (req_ch.req_type),
      .note_number (req_ch.note_number),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .env_level   (rsp_ch.env_level),
      .env_stage   (rsp_ch.env_stage),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

// ===== hw/rtl/adsr_checker.sv =====
// Port-level assertions for the envelope generator top, bound to it.
module adsr_checker #(
   parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [LEVEL_BITS-1:0]           rsp_env_level,
   input logic [adsr_pkg::STAGE_BITS-1:0] rsp_env_stage
);
   import adsr_pkg::*;

   // One request in work at a time: acceptance closes the request channel
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in work");

   // Reset empties the output register
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response word valid right after reset");

   // A stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_env_level) && $stable(rsp_env_stage)))
      else $error("stalled response word changed or dropped");

   // Only defined stages are reported
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_env_stage <= STG_ATTACK))
      else $error("response reports an undefined stage");

   // Idle is only ever entered at level zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_env_stage == STG_IDLE)) |-> (rsp_env_level == '0))
      else $error("idle stage reported with a nonzero level");

endmodule

bind adsr_envelope_generator_top adsr_checker #(
   .LEVEL_BITS (LEVEL_BITS)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_env_level (rsp_ch.env_level),
   .rsp_env_stage (rsp_ch.env_stage)
);
